// File: src/oale_pkg.sv
`timescale 1ns / 1ps

package oale_pkg;

  // Field widths of the command and result
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned LIMIT_W = 7;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_INSERT_AT   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_MODIFY_AT   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE_AT   = 4'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE_LAST = 4'd4;
  localparam logic [ACT_W-1:0] ACT_READ_AT     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_READ_LAST   = 4'd6;
  localparam logic [ACT_W-1:0] ACT_FIND_FIRST  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_COUNT       = 4'd8;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // Reset value of the capacity register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [CNT_W-1:0]         match_count;
    logic [CNT_W-1:0]         size_after;
  } oale_result_t;

endpackage

// File: src/oale_ram.sv
`timescale 1ns / 1ps

module oale_ram
  import oale_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/oale_ctrl.sv
`timescale 1ns / 1ps

module oale_ctrl
  import oale_pkg::*;
#(
  parameter int unsigned AW       = 6,
  parameter int unsigned FW       = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACT_W-1:0]  action,
  input  logic [IDX_W-1:0]  index,
  input  logic [DATA_W-1:0] value,
  input  logic [FW-1:0]     cap_eff,
  output logic              idle,
  output logic              done,
  output oale_result_t      res,
  input  logic              res_take,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [DATA_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [DATA_W-1:0] mem_rdata
);

  localparam int unsigned CW = (FW > IDX_W) ? FW : IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN, S_DONE} state_t;
  typedef enum logic [2:0] {M_NONE, M_UP, M_DN, M_READ, M_FIND, M_COUNT} mode_t;

  state_t            state;
  mode_t             mode;
  logic [FW-1:0]     fill;
  logic [FW-1:0]     fill_next;
  logic [FW-1:0]     left;
  logic [AW-1:0]     rd_addr;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic              fin_we;
  logic [AW-1:0]     fin_addr;
  logic              inc;
  logic              dec;
  logic [DATA_W-1:0] val;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] rd_val;
  logic              found;
  logic [AW-1:0]     pos;
  logic [FW-1:0]     cnt;
  logic              hit;

  // Decoded command
  mode_t             d_mode;
  logic [STAT_W-1:0] d_status;
  logic [FW-1:0]     d_left;
  logic [AW-1:0]     d_rd_addr;
  logic              d_fin_we;
  logic [AW-1:0]     d_fin_addr;
  logic              d_inc;
  logic              d_dec;
  logic [CW-1:0]     fill_w;
  logic [CW-1:0]     idx_w;
  logic [CW-1:0]     cap_w;

  // Check the command against fill and capacity, set up the walk
  always_comb begin
    fill_w     = CW'(fill);
    idx_w      = CW'(index);
    cap_w      = CW'(cap_eff);
    d_mode     = M_NONE;
    d_status   = ST_OK;
    d_left     = '0;
    d_rd_addr  = '0;
    d_fin_we   = 1'b0;
    d_fin_addr = AW'(index);
    d_inc      = 1'b0;
    d_dec      = 1'b0;
    case (action)
      ACT_INSERT_AT: begin
        if (idx_w > fill_w) begin
          d_status = ST_RANGE;
        end else if (fill_w >= cap_w) begin
          d_status = ST_FULL;
        end else begin
          d_mode    = M_UP;
          d_left    = FW'(fill_w - idx_w);
          d_rd_addr = AW'(fill_w - CW'(1));
          d_fin_we  = 1'b1;
          d_inc     = 1'b1;
        end
      end
      ACT_APPEND: begin
        if (fill_w >= cap_w) begin
          d_status = ST_FULL;
        end else begin
          d_fin_we   = 1'b1;
          d_fin_addr = AW'(fill);
          d_inc      = 1'b1;
        end
      end
      ACT_MODIFY_AT: begin
        if (idx_w >= fill_w) begin
          d_status = ST_RANGE;
        end else begin
          d_fin_we = 1'b1;
        end
      end
      ACT_REMOVE_AT: begin
        if (idx_w >= fill_w) begin
          d_status = ST_RANGE;
        end else begin
          d_mode    = M_DN;
          d_left    = FW'(fill_w - idx_w - CW'(1));
          d_rd_addr = AW'(idx_w + CW'(1));
          d_dec     = 1'b1;
        end
      end
      ACT_REMOVE_LAST: begin
        if (fill == '0) begin
          d_status = ST_EMPTY;
        end else begin
          d_dec = 1'b1;
        end
      end
      ACT_READ_AT: begin
        if (idx_w >= fill_w) begin
          d_status = ST_RANGE;
        end else begin
          d_mode    = M_READ;
          d_left    = FW'(1);
          d_rd_addr = AW'(index);
        end
      end
      ACT_READ_LAST: begin
        if (fill == '0) begin
          d_status = ST_EMPTY;
        end else begin
          d_mode    = M_READ;
          d_left    = FW'(1);
          d_rd_addr = AW'(fill_w - CW'(1));
        end
      end
      ACT_FIND_FIRST: begin
        d_mode   = M_FIND;
        d_status = ST_NOTFOUND;
        d_left   = fill;
      end
      ACT_COUNT: begin
        d_mode = M_COUNT;
        d_left = fill;
      end
      default: begin
        d_mode = M_NONE;
      end
    endcase
  end

  // Shared compare of the entry just read
  assign hit = (mem_rdata == val);

  always_comb begin
    if (inc) begin
      fill_next = fill + FW'(1);
    end else if (dec) begin
      fill_next = fill - FW'(1);
    end else begin
      fill_next = fill;
    end
  end

  // Memory ports: one read issued per walk cycle while reads remain, shifts write back each entry as its read returns
  assign mem_re    = (state == S_WALK) && (left != '0);
  assign mem_raddr = rd_addr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fin_addr;
    mem_wdata = val;
    if (state == S_WALK && pend && (mode == M_UP || mode == M_DN)) begin
      mem_we    = 1'b1;
      mem_wdata = mem_rdata;
      mem_waddr = (mode == M_UP) ? pend_addr + AW'(1) : pend_addr - AW'(1);
    end else if (state == S_FIN && fin_we) begin
      mem_we = 1'b1;
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (start) begin
            mode     <= d_mode;
            status   <= d_status;
            left     <= d_left;
            rd_addr  <= d_rd_addr;
            fin_we   <= d_fin_we;
            fin_addr <= d_fin_addr;
            inc      <= d_inc;
            dec      <= d_dec;
            val      <= value;
            rd_val   <= '0;
            found    <= 1'b0;
            pos      <= '0;
            cnt      <= '0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          // issue the next read
          pend      <= mem_re;
          pend_addr <= rd_addr;
          if (mem_re) begin
            left    <= left - FW'(1);
            rd_addr <= (mode == M_UP) ? rd_addr - AW'(1) : rd_addr + AW'(1);
          end
          // consume the entry read last cycle
          if (pend) begin
            case (mode)
              M_READ: rd_val <= mem_rdata;
              M_COUNT: begin
                if (hit) begin
                  cnt <= cnt + FW'(1);
                end
              end
              M_FIND: begin
                if (hit) begin
                  found  <= 1'b1;
                  pos    <= pend_addr;
                  status <= ST_OK;
                end
              end
              default: begin
                rd_val <= rd_val;
              end
            endcase
          end
          // finish once every read is consumed or the search hits
          if (left == '0 || (pend && mode == M_FIND && hit)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          fill               <= fill_next;
          res.status         <= status;
          res.read_value     <= rd_val;
          res.found_position <= found ? POS_W'(pos) : '0;
          res.match_count    <= CNT_W'(cnt);
          res.size_after     <= CNT_W'(fill_next);
          state              <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/ordered_array_list_engine_unit.sv
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values held in a CAPACITY-entry memory with
// a fill count; one request in, one result out. Requests are taken one at a
// time through a single memory read port, a single write port and one
// comparator walked by a sequencer. A request reads the entries moved by
// insert_at or remove_at, the filled entries for find_first (stopping at
// the first match) and count_matches, or the one entry for reads; other
// requests read no entry. The finished result sits in an output register,
// so the next request is taken while it waits. The capacity register
// (reset 64, saturated at CAPACITY) is to be written through the cfg port
// only while no request is in flight; the block itself does not enforce
// this.
module ordered_array_list_engine_unit
  import oale_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         action,
  input  logic [IDX_W-1:0]         index,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] read_value,
  output logic [POS_W-1:0]         found_position,
  output logic [CNT_W-1:0]         match_count,
  output logic [CNT_W-1:0]         size_after,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LIMIT_W-1:0]       cfg_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (FW > LIMIT_W) ? FW : LIMIT_W;

  logic [LIMIT_W-1:0] capacity_limit;
  logic [LW-1:0]      limit_w;
  logic [FW-1:0]      cap_eff;
  logic               start;
  logic               res_done;
  logic               res_take;
  oale_result_t       res;
  oale_result_t       out_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_limit <= cfg_data;
    end
  end

  // Saturate the limit at the built depth
  assign limit_w = LW'(capacity_limit);
  assign cap_eff = (limit_w > LW'(CAPACITY)) ? FW'(CAPACITY) : FW'(limit_w);

  assign start    = in_valid && in_ready;
  assign res_take = res_done && (!out_valid || out_ready);

  oale_ctrl #(
    .AW       (AW),
    .FW       (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .index     (index),
    .value     (value),
    .cap_eff   (cap_eff),
    .idle      (in_ready),
    .done      (res_done),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  oale_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result, hold it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign status         = out_q.status;
  assign read_value     = out_q.read_value;
  assign found_position = out_q.found_position;
  assign match_count    = out_q.match_count;
  assign size_after     = out_q.size_after;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a previous one was still in work");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_take |=> out_valid)
    else $error("handed-off result did not reach the output register");

  a_done_not_idle: assert property (@(posedge clk) disable iff (rst)
    res_done |-> !in_ready)
    else $error("sequencer idle while holding a result");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("shift wrote the entry being read in the same cycle");
`endif

endmodule
